// File: sv/dsn_pkg.sv
`timescale 1ns / 1ps
// dsn_pkg: shared types, constants and codes for the dataset scaling normalizer.
// No dependencies.
package dsn_pkg;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W = 32;
    localparam int SUM_W = 38;
    localparam int DSS_W = 56;

    typedef enum logic [2:0] {
        METH_ZSCORE = 3'd0,
        METH_CENTER = 3'd1,
        METH_SCALE  = 3'd2,
        METH_MINMAX = 3'd3,
        METH_ROBUST = 3'd4,
        METH_PASS   = 3'd5,
        METH_PASS6  = 3'd6,
        METH_PASS7  = 3'd7
    } method_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN,
        ST_DEV,
        ST_VAR,
        ST_SQRT,
        ST_QUART,
        ST_DEN,
        ST_EMIT_RD,
        ST_EMIT_DIV,
        ST_EMIT_OUT
    } state_t;

    // sort cell control
    typedef struct packed {
        logic ins;      // insert new value
        logic shift;    // rotate chain toward head (read out)
        logic clear;    // empty the chain
    } cell_ctl_t;
endpackage

// File: sv/dsn_sort_cell.sv
`timescale 1ns / 1ps
// dsn_sort_cell: one cell of the insertion sorting chain.
// Depends on dsn_pkg.
module dsn_sort_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dsn_pkg::cell_ctl_t             ctl,
    input  logic signed [dsn_pkg::DATA_W-1:0] new_val,
    input  logic signed [dsn_pkg::DATA_W-1:0] prev_val,
    input  logic                           prev_full,
    input  logic                           prev_gt,
    input  logic signed [dsn_pkg::DATA_W-1:0] next_val,
    input  logic                           next_full,
    input  logic signed [dsn_pkg::DATA_W-1:0] head_in,
    output logic signed [dsn_pkg::DATA_W-1:0] val,
    output logic                           full,
    output logic                           gt
);
    logic signed [dsn_pkg::DATA_W-1:0] val_reg, val_next;
    logic full_reg, full_next;

    // gt: this cell holds a value greater than the one being inserted
    assign gt = full_reg && (val_reg > new_val);
    assign val = val_reg;
    assign full = full_reg;

    always_comb
    begin
        val_next = val_reg;
        full_next = full_reg;
        if (ctl.clear)
        begin
            full_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            // rotate the filled part: the last filled cell takes the head value
            if (next_full)
            begin
                val_next = next_val;
            end
            else if (full_reg)
            begin
                val_next = head_in;
            end
        end
        else if (ctl.ins)
        begin
            if (gt)
            begin
                // shift right: take predecessor or the new value
                val_next = (prev_gt && prev_full) ? prev_val : new_val;
            end
            else if (!full_reg && prev_full)
            begin
                // first empty slot after the last filled cell
                val_next = (prev_gt && prev_full) ? prev_val : new_val;
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end
endmodule

// File: sv/dsn_sort_chain.sv
`timescale 1ns / 1ps
// dsn_sort_chain: row of dsn_sort_cell forming an ascending sorted list.
// Depends on dsn_pkg, dsn_sort_cell.
module dsn_sort_chain #(
    parameter int MAX_ITEMS = dsn_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dsn_pkg::cell_ctl_t                ctl,
    input  logic signed [dsn_pkg::DATA_W-1:0] new_val,
    output logic signed [dsn_pkg::DATA_W-1:0] head_val
);
    logic signed [dsn_pkg::DATA_W-1:0] vals [MAX_ITEMS+1];
    logic fulls [MAX_ITEMS+1];
    logic gts [MAX_ITEMS];

    // boundary: virtual cell before head is full and not greater; after tail empty
    assign vals[MAX_ITEMS] = '0;
    assign fulls[MAX_ITEMS] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++)
        begin : g_cell
            logic signed [dsn_pkg::DATA_W-1:0] pv;
            logic pf, pg;
            if (g == 0)
            begin : g_head
                assign pv = '0;
                assign pf = 1'b1;
                assign pg = 1'b0;
            end
            else
            begin : g_body
                assign pv = vals[g-1];
                assign pf = fulls[g-1];
                assign pg = gts[g-1];
            end
            dsn_sort_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .new_val  (new_val),
                .prev_val (pv),
                .prev_full(pf),
                .prev_gt  (pg),
                .next_val (vals[g+1]),
                .next_full(fulls[g+1]),
                .head_in  (vals[0]),
                .val      (vals[g]),
                .full     (fulls[g]),
                .gt       (gts[g])
            );
        end
    endgenerate

    assign head_val = vals[0];
endmodule

// File: sv/dsn_divider.sv
`timescale 1ns / 1ps
// dsn_divider: radix-2 restoring divider, unsigned, one quotient bit per cycle.
// No dependencies.
module dsn_divider #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);
    localparam int CW = $clog2(W+1);
    logic [W-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [W:0] trial;

    assign quo = q_reg;
    assign rem = r_reg;
    assign done = done_reg;
    assign trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

// File: sv/dataset_scaling_normalizer_core.sv
`timescale 1ns / 1ps
// dataset_scaling_normalizer_core: top level of the dataset scaling normalizer.
// Depends on dsn_pkg, dsn_sort_chain, dsn_divider.
//
// Samples are taken one per cycle while loading; present samples are inserted
// into a chain of sorting cells. After the item flagged final (or the one that
// fills the store) the block computes mean (one divider pass), deviation sum
// (one sorted value per cycle, rotated through the chain head), variance (one
// divider pass) and standard deviation (bit-serial square root, 32 steps), then
// quartiles (up to three rotations of the chain), then emits each sample in
// load order. A result that needs a division takes one pass of the shared
// 64-bit radix-2 divider; one that needs none does not use it. No clearing pass
// is needed.
module dataset_scaling_normalizer_core #(
    parameter int MAX_ITEMS = dsn_pkg::MAX_ITEMS_DEF,
    parameter int FRAC_BITS = dsn_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [dsn_pkg::DATA_W-1:0] sample,
    input  logic                              absent,
    input  logic                              final_req,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [dsn_pkg::DATA_W-1:0] scaled,
    output logic                              scaled_absent,
    output logic                              final_out
);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS+1);
    localparam int DW = 64;
    localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FRAC_BITS);
    localparam logic [dsn_pkg::DSS_W-1:0] DSS_MAX = '1;

    dsn_pkg::state_t state_reg, state_next;
    dsn_pkg::method_t method_reg;

    logic signed [dsn_pkg::DATA_W-1:0] samp_mem [MAX_ITEMS];
    logic absent_mem [MAX_ITEMS];
    logic signed [dsn_pkg::DATA_W-1:0] rd_samp_reg;
    logic rd_abs_reg;

    logic [CW-1:0] n_reg, n_next, m_reg, m_next, idx_reg, idx_next;
    logic signed [dsn_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [dsn_pkg::DSS_W-1:0] dss_reg, dss_next;
    logic signed [dsn_pkg::DATA_W-1:0] min_reg, min_next, max_reg, max_next;
    logic signed [DW-1:0] mean_reg, mean_next;
    logic [31:0] sd_reg, sd_next;
    logic [dsn_pkg::DSS_W-1:0] var_reg, var_next;
    logic [5:0] bit_reg, bit_next;
    logic [1:0] qk_reg, qk_next;
    logic signed [DW-1:0] q1_reg, q1_next, q2_reg, q2_next, q3_reg, q3_next;
    logic signed [DW-1:0] prev_reg, prev_next;
    logic signed [DW-1:0] num_reg, num_next;
    logic signed [DW-1:0] den_reg, den_next;
    logic neg_reg, neg_next, spec_reg, spec_next;
    logic signed [DW-1:0] spec_val_reg, spec_val_next;
    logic sub_reg, sub_next; // waiting on divider
    logic ov_reg, ov_next;
    logic signed [dsn_pkg::DATA_W-1:0] o_val_reg, o_val_next;
    logic o_abs_reg, o_abs_next, o_fin_reg, o_fin_next;

    dsn_pkg::cell_ctl_t ctl;
    logic signed [dsn_pkg::DATA_W-1:0] head;
    logic accept, ins_last;

    logic div_start, div_done;
    logic [DW-1:0] div_num, div_den, div_q, div_r;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != dsn_pkg::ST_LOAD);
    assign ins_last = final_req || (n_reg == CW'(MAX_ITEMS - 1));
    assign out_valid = ov_reg;
    assign scaled = o_val_reg;
    assign scaled_absent = o_abs_reg;
    assign final_out = o_fin_reg;

    dsn_sort_chain #(.MAX_ITEMS(MAX_ITEMS)) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .new_val (sample),
        .head_val(head)
    );

    dsn_divider #(.W(DW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .done (div_done),
        .quo  (div_q),
        .rem  (div_r)
    );

    // load-order store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_mem[n_reg[IW-1:0]] <= sample;
            absent_mem[n_reg[IW-1:0]] <= absent;
        end
        rd_samp_reg <= samp_mem[idx_reg[IW-1:0]];
        rd_abs_reg <= absent_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= dsn_pkg::METH_ZSCORE;
        end
        else if (cfg_we)
        begin
            method_reg <= dsn_pkg::method_t'(cfg_wdata);
        end
    end

    // signed/abs helpers
    logic signed [DW-1:0] d_ext, sq_c, sq_prod, tmp_a, tmp_b;
    logic [DW-1:0] mag, t_sq;
    logic [dsn_pkg::DSS_W:0] dss_add;
    logic [IW+1:0] h4;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        m_next = m_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        dss_next = dss_reg;
        min_next = min_reg;
        max_next = max_reg;
        mean_next = mean_reg;
        sd_next = sd_reg;
        var_next = var_reg;
        bit_next = bit_reg;
        qk_next = qk_reg;
        q1_next = q1_reg;
        q2_next = q2_reg;
        q3_next = q3_reg;
        prev_next = prev_reg;
        num_next = num_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        spec_next = spec_reg;
        spec_val_next = spec_val_reg;
        sub_next = sub_reg;
        ov_next = ov_reg;
        o_val_next = o_val_reg;
        o_abs_next = o_abs_reg;
        o_fin_next = o_fin_reg;
        ctl = '0;
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        d_ext = '0;
        mag = '0;
        t_sq = '0;
        dss_add = '0;
        sq_c = '0;
        sq_prod = '0;
        tmp_a = '0;
        tmp_b = '0;
        h4 = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            dsn_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    n_next = n_reg + 1'b1;
                    if (!absent)
                    begin
                        ctl.ins = 1'b1;
                        m_next = m_reg + 1'b1;
                        sum_next = sum_reg + dsn_pkg::SUM_W'(sample);
                        if (m_reg == '0 || sample < min_reg)
                        begin
                            min_next = sample;
                        end
                        if (m_reg == '0 || sample > max_reg)
                        begin
                            max_next = sample;
                        end
                    end
                    if (ins_last)
                    begin
                        state_next = dsn_pkg::ST_MEAN;
                        sub_next = 1'b0;
                    end
                end
            end
            dsn_pkg::ST_MEAN:
            begin
                // round(sum/m): floor((2s+m)/(2m)); a negative numerator is divided as a magnitude, then floored
                tmp_a = 2 * DW'(sum_reg) + DW'(m_reg);
                tmp_b = 2 * DW'(m_reg);
                if (m_reg == '0)
                begin
                    state_next = dsn_pkg::ST_EMIT_RD;
                    idx_next = '0;
                end
                else if (!sub_reg)
                begin
                    div_start = 1'b1;
                    neg_next = tmp_a[DW-1];
                    div_num = tmp_a[DW-1] ? DW'(-tmp_a) : tmp_a;
                    div_den = tmp_b;
                    sub_next = 1'b1;
                end
                else if (div_done)
                begin
                    sub_next = 1'b0;
                    if (neg_reg)
                    begin
                        mean_next = -$signed(div_q) - ((div_r != '0) ? 64'sd1 : 64'sd0);
                    end
                    else
                    begin
                        mean_next = $signed(div_q);
                    end
                    dss_next = '0;
                    idx_next = '0;
                    state_next = dsn_pkg::ST_DEV;
                end
            end
            dsn_pkg::ST_DEV:
            begin
                // rotate the chain: head goes out, comes back at tail position m
                d_ext = DW'(head) - mean_reg;
                mag = d_ext[DW-1] ? DW'(-d_ext) : d_ext;
                // |x - mean| fits in 32 bits
                t_sq = (DW'(mag[31:0]) * DW'(mag[31:0])) >> FRAC_BITS;
                dss_add = {1'b0, dss_reg} + (dsn_pkg::DSS_W+1)'(t_sq);
                if (t_sq > DW'(DSS_MAX - dss_reg))
                begin
                    dss_next = DSS_MAX;
                end
                else
                begin
                    dss_next = dss_add[dsn_pkg::DSS_W-1:0];
                end
                ctl.shift = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == m_reg - 1'b1)
                begin
                    state_next = dsn_pkg::ST_VAR;
                end
            end
            dsn_pkg::ST_VAR:
            begin
                if (m_reg == CW'(1))
                begin
                    sd_next = '0;
                    state_next = dsn_pkg::ST_QUART;
                    idx_next = '0;
                    qk_next = 2'd1;
                end
                else if (!sub_reg)
                begin
                    div_start = 1'b1;
                    div_num = DW'(dss_reg);
                    div_den = DW'(m_reg - 1'b1);
                    sub_next = 1'b1;
                end
                else if (div_done)
                begin
                    sub_next = 1'b0;
                    var_next = div_q[dsn_pkg::DSS_W-1:0];
                    sd_next = '0;
                    bit_next = 6'd31;
                    state_next = dsn_pkg::ST_SQRT;
                end
            end
            dsn_pkg::ST_SQRT:
            begin
                sq_c = DW'(sd_reg) | (64'sd1 <<< bit_reg);
                sq_prod = DW'((DW'(sq_c[31:0]) * DW'(sq_c[31:0])) >> FRAC_BITS);
                if ($unsigned(sq_prod) <= DW'(var_reg))
                begin
                    sd_next = sq_c[31:0];
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = dsn_pkg::ST_QUART;
                    idx_next = '0;
                    qk_next = 2'd1;
                end
            end
            dsn_pkg::ST_QUART:
            begin
                // stream the sorted chain; pick s[lo], s[lo+1] for each quartile
                h4 = (IW+2)'(m_reg - 1'b1) * (IW+2)'(qk_reg);
                ctl.shift = 1'b1;
                prev_next = DW'(head);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(h4[IW+1:2]) + CW'(h4[1:0] != 2'd0))
                begin
                    if (h4[1:0] == 2'd0)
                    begin
                        tmp_a = 4 * DW'(head);
                    end
                    else
                    begin
                        tmp_a = 4 * prev_reg + DW'(h4[1:0]) * (DW'(head) - prev_reg);
                    end
                    case (qk_reg)
                        2'd1: q1_next = tmp_a;
                        2'd2: q2_next = tmp_a;
                        default: q3_next = tmp_a;
                    endcase
                    qk_next = qk_reg + 1'b1;
                    if (qk_reg == 2'd3)
                    begin
                        ctl.shift = 1'b0;
                        ctl.clear = 1'b1;
                        idx_next = '0;
                        state_next = dsn_pkg::ST_EMIT_RD;
                    end
                    else
                    begin
                        // restart: rotate the rest back to re-align to head
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (idx_reg == m_reg - 1'b1 && state_next == dsn_pkg::ST_QUART)
                begin
                    idx_next = '0;
                end
            end
            dsn_pkg::ST_EMIT_RD:
            begin
                state_next = dsn_pkg::ST_DEN;
            end
            dsn_pkg::ST_DEN:
            begin
                spec_next = 1'b0;
                num_next = '0;
                den_next = 64'sd1;
                spec_val_next = '0;
                case (method_reg)
                    dsn_pkg::METH_ZSCORE:
                    begin
                        if (sd_reg == '0)
                        begin
                            spec_next = 1'b1;
                        end
                        num_next = (DW'(rd_samp_reg) - mean_reg) <<< FRAC_BITS;
                        den_next = DW'(sd_reg);
                    end
                    dsn_pkg::METH_CENTER:
                    begin
                        spec_next = 1'b1;
                        spec_val_next = DW'(rd_samp_reg) - mean_reg;
                    end
                    dsn_pkg::METH_SCALE:
                    begin
                        if (sd_reg == '0)
                        begin
                            spec_next = 1'b1;
                            spec_val_next = ONE;
                        end
                        num_next = DW'(rd_samp_reg) <<< FRAC_BITS;
                        den_next = DW'(sd_reg);
                    end
                    dsn_pkg::METH_MINMAX:
                    begin
                        if (max_reg == min_reg)
                        begin
                            spec_next = 1'b1;
                            spec_val_next = ONE >>> 1;
                        end
                        num_next = (DW'(rd_samp_reg) - DW'(min_reg)) <<< FRAC_BITS;
                        den_next = DW'(max_reg) - DW'(min_reg);
                    end
                    dsn_pkg::METH_ROBUST:
                    begin
                        if (q3_reg == q1_reg)
                        begin
                            spec_next = 1'b1;
                        end
                        num_next = (4 * DW'(rd_samp_reg) - q2_reg) <<< FRAC_BITS;
                        den_next = q3_reg - q1_reg;
                    end
                    default:
                    begin
                        spec_next = 1'b1;
                        spec_val_next = DW'(rd_samp_reg);
                    end
                endcase
                if (rd_abs_reg || m_reg == '0)
                begin
                    spec_next = 1'b1;
                    spec_val_next = '0;
                end
                state_next = dsn_pkg::ST_EMIT_DIV;
                sub_next = 1'b0;
            end
            dsn_pkg::ST_EMIT_DIV:
            begin
                tmp_a = 2 * num_reg + den_reg;
                if (spec_reg)
                begin
                    state_next = dsn_pkg::ST_EMIT_OUT;
                end
                else if (!sub_reg)
                begin
                    div_start = 1'b1;
                    neg_next = tmp_a[DW-1];
                    div_num = tmp_a[DW-1] ? DW'(-tmp_a) : tmp_a;
                    div_den = DW'(2 * den_reg);
                    sub_next = 1'b1;
                end
                else if (div_done)
                begin
                    sub_next = 1'b0;
                    spec_next = 1'b1;
                    if (neg_reg)
                    begin
                        spec_val_next = -$signed(div_q) - ((div_r != '0) ? 64'sd1 : 64'sd0);
                    end
                    else
                    begin
                        spec_val_next = $signed(div_q);
                    end
                end
            end
            dsn_pkg::ST_EMIT_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    if (spec_val_reg > 64'sd2147483647)
                    begin
                        o_val_next = 32'sh7FFFFFFF;
                    end
                    else if (spec_val_reg < -64'sd2147483648)
                    begin
                        o_val_next = 32'sh80000000;
                    end
                    else
                    begin
                        o_val_next = spec_val_reg[31:0];
                    end
                    o_abs_next = rd_abs_reg || (m_reg == '0);
                    o_fin_next = (idx_reg + 1'b1 == n_reg);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == n_reg)
                    begin
                        state_next = dsn_pkg::ST_LOAD;
                        n_next = '0;
                        m_next = '0;
                        sum_next = '0;
                        idx_next = '0;
                        ctl.clear = 1'b1;
                    end
                    else
                    begin
                        state_next = dsn_pkg::ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = dsn_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsn_pkg::ST_LOAD;
            n_reg <= '0;
            m_reg <= '0;
            idx_reg <= '0;
            sum_reg <= '0;
            sub_reg <= 1'b0;
            ov_reg <= 1'b0;
            min_reg <= '0;
            max_reg <= '0;
            dss_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            m_reg <= m_next;
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            sub_reg <= sub_next;
            ov_reg <= ov_next;
            min_reg <= min_next;
            max_reg <= max_next;
            dss_reg <= dss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        sd_reg <= sd_next;
        var_reg <= var_next;
        bit_reg <= bit_next;
        qk_reg <= qk_next;
        q1_reg <= q1_next;
        q2_reg <= q2_next;
        q3_reg <= q3_next;
        prev_reg <= prev_next;
        num_reg <= num_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        spec_reg <= spec_next;
        spec_val_reg <= spec_val_next;
        o_val_reg <= o_val_next;
        o_abs_reg <= o_abs_next;
        o_fin_reg <= o_fin_next;
    end
endmodule

// File: sv/dsn_checker.sv
`timescale 1ns / 1ps
// dsn_checker: port-level assertions for dataset_scaling_normalizer_core.
// Depends on dsn_pkg only through the bound top level.
module dsn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] scaled,
    input logic        scaled_absent,
    input logic        final_out
);
    // a missing result carries zero
    a_abs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scaled_absent |-> scaled == '0)
        else $error("missing result with nonzero value");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scaled) && $stable(final_out))
        else $error("stalled result changed");

    // no input taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_out |-> in_stall)
        else $error("input accepted during emission");
endmodule

bind dataset_scaling_normalizer_core dsn_checker u_dsn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scaled       (scaled),
    .scaled_absent(scaled_absent),
    .final_out    (final_out)
);

// File: tb/sv/tb_dataset_scaling_normalizer_core.sv
`timescale 1ns / 1ps
// tb_dataset_scaling_normalizer_core: self-checking bench for the scaling normalizer.
// Depends on dsn_pkg and dataset_scaling_normalizer_core; predicts every result set
// from a behavioral copy of the set statistics and checks outputs in order.
module tb_dataset_scaling_normalizer_core;
    localparam int NMAX = 64;
    localparam int FB = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam longint unsigned DSS_TOP = (64'd1 << 56) - 64'd1;

    typedef struct {
        logic signed [31:0] value;
        bit                 miss;
        bit                 last;
    } sample_txn_t;

    typedef struct {
        logic signed [31:0] value;
        bit                 miss;
        bit                 last;
    } scaled_txn_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] sample;
    logic absent;
    logic final_req;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] scaled;
    logic scaled_absent;
    logic final_out;

    dataset_scaling_normalizer_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .absent(absent), .final_req(final_req),
        .out_valid(out_valid), .out_stall(out_stall),
        .scaled(scaled), .scaled_absent(scaled_absent), .final_out(final_out)
    );

    sample_txn_t sample_q[$];
    scaled_txn_t scaled_q[$];

    // predictor state
    dsn_pkg::method_t mode_r;
    longint set_vals[NMAX];
    bit set_miss[NMAX];
    longint ordered[NMAX];
    int n_items;
    int n_present;
    longint total;
    longint lo_seen;
    longint hi_seen;

    int mismatches;
    bit quiet;
    bit hold_req;
    int hold_left;
    bit hold_done;
    int src_gap;
    int snk_gap;
    int cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // nearest, ties upward; d > 0
    function automatic longint round_div(longint n, longint d);
        longint num;
        longint den;
        longint q;
        num = 2 * n + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q--;
        return q;
    endfunction

    function automatic longint quart4(int m, int k);
        int h4;
        int lo;
        longint q;
        h4 = (m - 1) * k;
        lo = h4 / 4;
        q = 4 * ordered[lo];
        if ((h4 % 4) != 0)
            q += (h4 % 4) * (ordered[lo + 1] - ordered[lo]);
        return q;
    endfunction

    function automatic void predict_scaling(sample_txn_t t);
        longint x;
        longint one;
        longint mean;
        longint sd;
        longint med4;
        longint iqr4;
        longint span;
        longint v;
        longint d;
        longint unsigned dss;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned var_u;
        longint unsigned root;
        longint unsigned cand;
        int p;
        bit na;
        scaled_txn_t r;
        x = longint'(t.value);
        one = longint'(1) << FB;
        mean = 0; sd = 0; med4 = 0; iqr4 = 0; span = 0;
        set_vals[n_items] = x;
        set_miss[n_items] = t.miss;
        n_items++;
        if (!t.miss)
        begin
            p = n_present;
            while (p > 0 && ordered[p - 1] > x)
            begin
                ordered[p] = ordered[p - 1];
                p--;
            end
            ordered[p] = x;
            if (n_present == 0 || x < lo_seen)
                lo_seen = x;
            if (n_present == 0 || x > hi_seen)
                hi_seen = x;
            n_present++;
            total += x;
        end
        if (!t.last && n_items < NMAX)
            return;

        if (n_present > 0)
        begin
            mean = round_div(total, n_present);
            dss = 0;
            for (int i = 0; i < n_present; i++)
            begin
                d = ordered[i] - mean;
                mag = (d < 0) ? longint'(-d) : longint'(d);
                sq = (mag * mag) >> FB;
                if (sq > DSS_TOP - dss)
                    dss = DSS_TOP;
                else
                    dss += sq;
            end
            if (n_present > 1)
            begin
                var_u = dss / longint'(n_present - 1);
                root = 0;
                for (int b = 31; b >= 0; b--)
                begin
                    cand = root | (64'd1 << b);
                    if (((cand * cand) >> FB) <= var_u)
                        root = cand;
                end
                sd = longint'(root);
            end
            span = hi_seen - lo_seen;
            med4 = quart4(n_present, 2);
            iqr4 = quart4(n_present, 3) - quart4(n_present, 1);
        end

        for (int i = 0; i < n_items; i++)
        begin
            na = set_miss[i] || n_present == 0;
            v = 0;
            if (!na)
            begin
                case (mode_r)
                    dsn_pkg::METH_ZSCORE:
                        v = (sd == 0) ? 0 : round_div((set_vals[i] - mean) * one, sd);
                    dsn_pkg::METH_CENTER: v = set_vals[i] - mean;
                    dsn_pkg::METH_SCALE:
                        v = (sd == 0) ? one : round_div(set_vals[i] * one, sd);
                    dsn_pkg::METH_MINMAX: v = (span == 0) ? (one >> 1)
                                     : round_div((set_vals[i] - lo_seen) * one, span);
                    dsn_pkg::METH_ROBUST: v = (iqr4 == 0) ? 0
                                     : round_div((4 * set_vals[i] - med4) * one, iqr4);
                    default:     v = set_vals[i];
                endcase
            end
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            else if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            r.value = v[31:0];
            r.miss = na;
            r.last = (i + 1 == n_items);
            scaled_q = {scaled_q, r};
        end
        n_items = 0;
        n_present = 0;
        total = 0;
    endfunction

    // sender: accepts, predicts, then offers the next queued sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            absent <= 1'b0;
            final_req <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_scaling('{sample, absent, final_req});
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    in_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (sample_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    sample <= sample_q[0].value;
                    absent <= sample_q[0].miss;
                    final_req <= sample_q[0].last;
                    void'(sample_q.pop_front());
                    if (!quiet && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left <= 700;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver: checks every accepted transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (scaled_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: scaled=%0d absent=%0b final=%0b",
                                 scaled, scaled_absent, final_out);
                end
                else
                begin
                    if (scaled !== scaled_q[0].value || scaled_absent !== scaled_q[0].miss
                        || final_out !== scaled_q[0].last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     scaled_q[0].value, scaled_q[0].miss, scaled_q[0].last,
                                     scaled, scaled_absent, final_out);
                    end
                    void'(scaled_q.pop_front());
                end
            end
            if (snk_gap > 0)
            begin
                out_stall <= 1'b1;
                snk_gap <= snk_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                snk_gap <= $urandom_range(0, 3);
            end
            else
                out_stall <= (hold_left > 1);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_dataset_scaling_normalizer_core failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_value(int kind, logic signed [31:0] base);
        case (kind)
            0: return $urandom;
            1: return ($urandom_range(0, 40) << FB) - (20 << FB) + $urandom_range(0, 3);
            2: return base;
            default:
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 0;
                    default: return -1;
                endcase
        endcase
    endfunction

    task automatic add_item(logic signed [31:0] v, bit miss, bit last);
        sample_txn_t t;
        t.value = v;
        t.miss = miss;
        t.last = last;
        sample_q = {sample_q, t};
    endtask

    // len items, final flag on the last unless the set ends by filling the store
    task automatic add_set(int len, int kind, int miss_pct, bit flag_last);
        logic signed [31:0] base;
        base = pick_value(0, 0);
        for (int i = 0; i < len; i++)
            add_item(pick_value(kind, base), $urandom_range(0, 99) < miss_pct,
                     flag_last && i == len - 1);
    endtask

    task automatic drain_and_set(dsn_pkg::method_t m);
        while (sample_q.size() != 0 || in_valid || scaled_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        mismatches = 0;
        cycles = 0;
        mode_r = dsn_pkg::METH_ZSCORE;
        n_items = 0;
        n_present = 0;
        total = 0;
        lo_seen = 0;
        hi_seen = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, single present, all missing, constant set, mixed
        drain_and_set(dsn_pkg::METH_ZSCORE);
        mode_r = dsn_pkg::METH_ZSCORE;
        add_item(32'sh7fffffff, 0, 0);
        add_item(32'sh80000000, 0, 1);
        add_item(32'sh00010000, 0, 1);
        add_item(32'sh00050000, 1, 0);
        add_item(32'sh00020000, 1, 1);
        add_item(32'sh00030000, 0, 0);
        add_item(32'sh00030000, 0, 0);
        add_item(32'sh00030000, 1, 0);
        add_item(32'sh00030000, 0, 1);
        add_item(32'sh80000000, 0, 0);
        add_item(32'sh80000000, 0, 0);
        add_item(32'sh7fffffff, 0, 0);
        add_item(32'sh7fffffff, 0, 0);
        add_item(32'sh00000001, 1, 0);
        add_item(-32'sh00010000, 0, 1);
        add_item(32'sh00000000, 0, 0);
        add_item(32'sh00018000, 0, 0);
        add_item(-32'sh00028000, 0, 0);
        add_item(32'sh00040000, 0, 0);
        add_item(32'sh00008000, 0, 1);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_and_set(dsn_pkg::method_t'(ph));
            mode_r = dsn_pkg::method_t'(ph);
            if (ph == 7)
                quiet = 1'b1;
            if (ph == 4)
                hold_req = 1'b1;
            if (ph == 1 || ph == 5)
                add_set(64, $urandom_range(0, 3), 10, ph == 5);
            for (int s = 0; s < 8; s++)
            begin
                len = $urandom_range(1, 10);
                case ($urandom_range(0, 9))
                    0: add_set(len, 0, 100, 1);
                    1: add_set(len, 2, 10, 1);
                    2: add_set(len, 3, 10, 1);
                    3, 4: add_set(len, 0, 15, 1);
                    default: add_set(len, 1, 15, 1);
                endcase
            end
        end

        while (sample_q.size() != 0 || in_valid || scaled_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && scaled_q.size() == 0)
            $display("tb_dataset_scaling_normalizer_core passed");
        else
            $display("tb_dataset_scaling_normalizer_core failed");
        $finish;
    end
endmodule

// File: filelist.f
sv/dsn_pkg.sv
sv/dsn_sort_cell.sv
sv/dsn_sort_chain.sv
sv/dsn_divider.sv
sv/dataset_scaling_normalizer_core.sv
sv/dsn_checker.sv
tb/sv/tb_dataset_scaling_normalizer_core.sv
